// File: src/rsi_pkg.sv
package rsi_pkg;

	// Q16.16 operands, Q1.14 normals
	localparam int FRAC_BITS = 16;
	localparam int NORM_BITS = 14;

	localparam int COORD_W  = 32;
	localparam int RADIUS_W = 31;
	localparam int NORMAL_W = 16;

	// config register indexes
	localparam logic [1:0] REG_RADIUS   = 2'd0;
	localparam logic [1:0] REG_CENTER_X = 2'd1;
	localparam logic [1:0] REG_CENTER_Y = 2'd2;
	localparam logic [1:0] REG_CENTER_Z = 2'd3;

	localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1 << FRAC_BITS);

	// wide datapath widths
	localparam int MUL_W   = 64;
	localparam int DISC_W  = 2 * MUL_W;
	localparam int ROOT_W  = DISC_W / 2;
	localparam int TMAG_W  = 34;
	localparam int RNUM_W  = 65 + FRAC_BITS;
	localparam int RDEN_W  = 62;
	localparam int NNUM_W  = 64 + NORM_BITS;
	localparam int NDEN_W  = RADIUS_W + FRAC_BITS;
	localparam int NQUO_W  = NORMAL_W - 1;

	localparam logic [TMAG_W-1:0] T_CLAMP = TMAG_W'(1) << (TMAG_W - 1);

endpackage

// File: src/rsi_mul64.sv
module rsi_mul64 import rsi_pkg::*; #(
	parameter int W    = MUL_W,
	parameter int SB_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [W-1:0]      in_a,
	input  logic [W-1:0]      in_b,
	input  logic [SB_W-1:0]   in_sb,
	output logic              out_valid,
	output logic [2*W-1:0]    out_prod,
	output logic [SB_W-1:0]   out_sb
);

	localparam int H = W / 2;

	logic            valid_s1;
	logic [W-1:0]    p00_s1, p01_s1, p10_s1, p11_s1;
	logic [SB_W-1:0] sb_s1;
	logic            valid_s2;
	logic [2*W-1:0]  prod_s2;
	logic [SB_W-1:0] sb_s2;

	// stage 1: four half-width partial products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		p00_s1 <= in_a[H-1:0] * in_b[H-1:0];
		p01_s1 <= in_a[H-1:0] * in_b[W-1:H];
		p10_s1 <= in_a[W-1:H] * in_b[H-1:0];
		p11_s1 <= in_a[W-1:H] * in_b[W-1:H];
		sb_s1  <= in_sb;
		// stage 2: align and sum
		prod_s2 <= (2*W)'(p00_s1) + ((2*W)'(p01_s1) << H) + ((2*W)'(p10_s1) << H)
			+ ((2*W)'(p11_s1) << W);
		sb_s2   <= sb_s1;
	end

	assign out_valid = valid_s2;
	assign out_prod  = prod_s2;
	assign out_sb    = sb_s2;

endmodule

// File: src/rsi_sqrt.sv
module rsi_sqrt import rsi_pkg::*; #(
	parameter int IN_W = DISC_W,
	parameter int SB_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [IN_W-1:0]     in_rad,
	input  logic [SB_W-1:0]     in_sb,
	output logic                out_valid,
	output logic [IN_W/2-1:0]   out_root,
	output logic [SB_W-1:0]     out_sb
);

	localparam int OUT_W = IN_W / 2;
	localparam int REM_W = OUT_W + 3;

	// index 0 is the input, index k+1 the register after digit step k
	logic              valid_s [0:OUT_W];
	logic [REM_W-1:0]  rem_s   [0:OUT_W];
	logic [OUT_W-1:0]  root_s  [0:OUT_W];
	logic [IN_W-1:0]   rad_s   [0:OUT_W];
	logic [SB_W-1:0]   sb_s    [0:OUT_W];

	assign valid_s[0] = in_valid;
	assign rem_s[0]   = '0;
	assign root_s[0]  = '0;
	assign rad_s[0]   = in_rad;
	assign sb_s[0]    = in_sb;

	for (genvar k = 0; k < OUT_W; k++) begin : g_step
		logic [REM_W-1:0] cur;
		logic [REM_W-1:0] trial;
		logic             ge;

		// one result bit per step: bring down two radicand bits, try root*4+1
		assign cur   = {rem_s[k][REM_W-3:0], rad_s[k][IN_W-1:IN_W-2]};
		assign trial = {1'b0, root_s[k], 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? (cur - trial) : cur;
			root_s[k+1] <= {root_s[k][OUT_W-2:0], ge};
			rad_s[k+1]  <= rad_s[k] << 2;
			sb_s[k+1]   <= sb_s[k];
		end
	end

	assign out_valid = valid_s[OUT_W];
	assign out_root  = root_s[OUT_W];
	assign out_sb    = sb_s[OUT_W];

endmodule

// File: src/rsi_div.sv
module rsi_div import rsi_pkg::*; #(
	parameter int NUM_W = RNUM_W,
	parameter int DEN_W = RDEN_W,
	parameter int QUO_W = TMAG_W,
	parameter int SB_W  = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  in_num,
	input  logic [DEN_W-1:0]  in_den,
	input  logic [SB_W-1:0]   in_sb,
	output logic              out_valid,
	output logic [QUO_W-1:0]  out_quo,
	output logic              out_ovf,
	output logic [SB_W-1:0]   out_sb
);

	localparam int HI_W  = NUM_W - QUO_W;
	localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

	logic              valid_s [0:QUO_W];
	logic [DEN_W-1:0]  rem_s   [0:QUO_W];
	logic [DEN_W-1:0]  den_s   [0:QUO_W];
	logic [QUO_W-1:0]  low_s   [0:QUO_W];
	logic [QUO_W-1:0]  quo_s   [0:QUO_W];
	logic              ovf_s   [0:QUO_W];
	logic [SB_W-1:0]   sb_s    [0:QUO_W];

	logic [CMP_W-1:0]  hi_ext;

	// quotient overflows QUO_W bits when the top part already reaches den
	assign hi_ext = CMP_W'(in_num[NUM_W-1:QUO_W]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ovf_s[0] <= (hi_ext >= CMP_W'(in_den));
		rem_s[0] <= hi_ext[DEN_W-1:0];
		den_s[0] <= in_den;
		low_s[0] <= in_num[QUO_W-1:0];
		quo_s[0] <= '0;
		sb_s[0]  <= in_sb;
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [DEN_W:0] cur;
		logic [DEN_W:0] diff;
		logic           ge;

		assign cur  = {rem_s[k], low_s[k][QUO_W-1]};
		assign diff = cur - {1'b0, den_s[k]};
		assign ge   = (cur >= {1'b0, den_s[k]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
			den_s[k+1] <= den_s[k];
			low_s[k+1] <= low_s[k] << 1;
			quo_s[k+1] <= {quo_s[k][QUO_W-2:0], ge};
			ovf_s[k+1] <= ovf_s[k];
			sb_s[k+1]  <= sb_s[k];
		end
	end

	assign out_valid = valid_s[QUO_W];
	assign out_quo   = quo_s[QUO_W];
	assign out_ovf   = ovf_s[QUO_W];
	assign out_sb    = sb_s[QUO_W];

endmodule

// File: src/ray_sphere_intersect.sv
// Ray/sphere intersection, fully pipelined. A request (start while busy is low)
// carries one ray: origin, direction and the open interval (t_min, t_max). busy
// is always low, so a request is taken every cycle. Each request gives exactly
// one result, shown for one cycle with done high, in request order; the
// receiver cannot stall, and none is needed since nothing in the pipe ever
// waits. Latency is set by the chain of bit-serial units: the 64-step square root
// of the discriminant, the root divider and the normal divider, plus the setup,
// 64x64 multiply and select stages around them. The sphere center and radius
// sit in config registers, written through cfg_wr_en/cfg_index/cfg_data; they
// feed the pipe live, so write them only when no request is in flight. On a
// miss (no root strictly inside the interval, zero-length direction, or a
// discriminant that is not strictly positive) hit is low, t_hit returns t_max
// and the normal is zero.
module ray_sphere_intersect import rsi_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [1:0]                  cfg_index,
	input  logic [COORD_W-1:0]          cfg_data,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [COORD_W-1:0]   origin_x,
	input  logic signed [COORD_W-1:0]   origin_y,
	input  logic signed [COORD_W-1:0]   origin_z,
	input  logic signed [COORD_W-1:0]   dir_x,
	input  logic signed [COORD_W-1:0]   dir_y,
	input  logic signed [COORD_W-1:0]   dir_z,
	input  logic signed [COORD_W-1:0]   t_min,
	input  logic signed [COORD_W-1:0]   t_max,
	output logic                        done,
	output logic                        hit,
	output logic signed [COORD_W-1:0]   t_hit,
	output logic signed [NORMAL_W-1:0]  normal_x,
	output logic signed [NORMAL_W-1:0]  normal_y,
	output logic signed [NORMAL_W-1:0]  normal_z
);

	// per-ray data that rides along the pipe
	typedef struct packed {
		logic [2:0][COORD_W:0]   oc;   // origin - center, 33 bit signed
		logic [2:0][COORD_W-1:0] d;
		logic [COORD_W-1:0]      t_lo;
		logic [COORD_W-1:0]      t_hi;
	} pay_t;

	typedef struct packed {
		logic [MUL_W-1:0]  bs;
		logic [RDEN_W-1:0] as;
		pay_t              pay;
	} mul_sb_t;

	typedef struct packed {
		logic              ok;
		logic [MUL_W-1:0]  bs;
		logic [RDEN_W-1:0] as;
		pay_t              pay;
	} sq_sb_t;

	typedef struct packed {
		logic neg;
		logic ok;
		pay_t pay;
	} rt_sb_t;

	typedef struct packed {
		logic               neg;
		logic               hit;
		logic [COORD_W-1:0] t;
		logic [COORD_W-1:0] t_hi;
	} nm_sb_t;

	// ---------------------------------------------------------------- config
	logic [RADIUS_W-1:0] radius_q;
	logic [COORD_W-1:0]  center_q [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= RADIUS_RESET;
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_RADIUS:   radius_q    <= cfg_data[RADIUS_W-1:0];
				REG_CENTER_X: center_q[0] <= cfg_data;
				REG_CENTER_Y: center_q[1] <= cfg_data;
				REG_CENTER_Z: center_q[2] <= cfg_data;
				default:      radius_q    <= radius_q;
			endcase
		end
	end

	assign busy = 1'b0;

	// ------------------------------------------------ stage 1: oc = e - c
	logic              valid_s1;
	pay_t              pay_s1;
	logic [COORD_W-1:0] org [0:2];
	logic [COORD_W-1:0] dir [0:2];

	assign org[0] = origin_x;
	assign org[1] = origin_y;
	assign org[2] = origin_z;
	assign dir[0] = dir_x;
	assign dir[1] = dir_y;
	assign dir[2] = dir_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pay_s1.oc[i] <= {org[i][COORD_W-1], org[i]}
				- {center_q[i][COORD_W-1], center_q[i]};
			pay_s1.d[i]  <= dir[i];
		end
		pay_s1.t_lo <= t_min;
		pay_s1.t_hi <= t_max;
	end

	// ------------------------------------------- stage 2: component products
	logic              valid_s2;
	pay_t              pay_s2;
	logic [63:0]       dd_s2 [0:2];   // d*d
	logic [64:0]       dq_s2 [0:2];   // d*oc, signed
	logic [64:0]       qq_s2 [0:2];   // oc*oc
	logic [61:0]       rr_s2;         // r*r

	logic signed [63:0] dd_w [0:2];
	logic signed [64:0] dq_w [0:2];
	logic signed [65:0] qq_w [0:2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dd_w[i] = $signed(pay_s1.d[i]) * $signed(pay_s1.d[i]);
			dq_w[i] = $signed(pay_s1.d[i]) * $signed(pay_s1.oc[i]);
			qq_w[i] = $signed(pay_s1.oc[i]) * $signed(pay_s1.oc[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			dd_s2[i] <= dd_w[i];
			dq_s2[i] <= dq_w[i];
			qq_s2[i] <= qq_w[i][64:0];
		end
		rr_s2  <= 62'(radius_q) * 62'(radius_q);
		pay_s2 <= pay_s1;
	end

	// ------------------------------ stage 3: A, b, C and their quarters
	logic              valid_s3;
	pay_t              pay_s3;
	logic [RDEN_W-1:0] as_s3;
	logic [MUL_W-1:0]  bs_s3;
	logic [MUL_W-1:0]  cs_s3;

	logic [63:0] a_sum;
	logic [66:0] b_sum;
	logic [67:0] c_sum;

	always_comb begin
		a_sum = dd_s2[0] + dd_s2[1] + dd_s2[2];
		b_sum = {{2{dq_s2[0][64]}}, dq_s2[0]} + {{2{dq_s2[1][64]}}, dq_s2[1]}
			+ {{2{dq_s2[2][64]}}, dq_s2[2]};
		// C may wrap past 64 bits after the quarter; kept as the low 64 bits
		c_sum = {3'b000, qq_s2[0]} + {3'b000, qq_s2[1]} + {3'b000, qq_s2[2]}
			- {6'b000000, rr_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		as_s3  <= a_sum[63:2];
		bs_s3  <= b_sum[65:2];
		cs_s3  <= c_sum[65:2];
		pay_s3 <= pay_s2;
	end

	// --------------------------------------- stage 4: magnitudes for squares
	logic              valid_s4;
	mul_sb_t           msb_s4;
	logic [MUL_W-1:0]  bmag_s4;
	logic [MUL_W-1:0]  cmag_s4;
	logic              cneg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		bmag_s4     <= bs_s3[MUL_W-1] ? (MUL_W'(0) - bs_s3) : bs_s3;
		cmag_s4     <= cs_s3[MUL_W-1] ? (MUL_W'(0) - cs_s3) : cs_s3;
		cneg_s4     <= cs_s3[MUL_W-1];
		msb_s4.bs   <= bs_s3;
		msb_s4.as   <= as_s3;
		msb_s4.pay  <= pay_s3;
	end

	// ------------------------- bs*bs and as*|cs|, split 64x64 multipliers
	logic              mb_valid;
	logic [DISC_W-1:0] bsq;
	logic [DISC_W-1:0] acp;
	mul_sb_t           mb_sb;
	logic              mc_cneg;

	rsi_mul64 #(.W(MUL_W), .SB_W($bits(mul_sb_t))) u_mul_b (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s4),
		.in_a      (bmag_s4),
		.in_b      (bmag_s4),
		.in_sb     (msb_s4),
		.out_valid (mb_valid),
		.out_prod  (bsq),
		.out_sb    (mb_sb)
	);

	rsi_mul64 #(.W(MUL_W), .SB_W(1)) u_mul_c (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s4),
		.in_a      (MUL_W'(msb_s4.as)),
		.in_b      (cmag_s4),
		.in_sb     (cneg_s4),
		.out_valid (),
		.out_prod  (acp),
		.out_sb    (mc_cneg)
	);

	// ------------------------------------- stage 5: discriminant bs^2 - as*cs
	logic              valid_s5;
	logic [DISC_W-1:0] disc_s5;
	mul_sb_t           msb_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= mb_valid;
		end
	end

	always_ff @(posedge clk) begin
		disc_s5 <= mc_cneg ? (bsq + acp) : (bsq - acp);
		msb_s5  <= mb_sb;
	end

	// hit needs a real direction and a strictly positive discriminant
	sq_sb_t sq_in_sb;

	always_comb begin
		sq_in_sb.ok  = (msb_s5.as != '0) && !disc_s5[DISC_W-1] && (disc_s5 != '0);
		sq_in_sb.bs  = msb_s5.bs;
		sq_in_sb.as  = msb_s5.as;
		sq_in_sb.pay = msb_s5.pay;
	end

	// ---------------------------------------------- floor(sqrt(disc))
	logic              sq_valid;
	logic [ROOT_W-1:0] sq_root;
	sq_sb_t            sq_sb;

	rsi_sqrt #(.IN_W(DISC_W), .SB_W($bits(sq_sb_t))) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s5),
		.in_rad    (disc_s5),
		.in_sb     (sq_in_sb),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_sb    (sq_sb)
	);

	// ------------------------------- stage 6: numerators -bs -/+ s
	logic              valid_s6;
	logic [65:0]       nn_s6;
	logic [65:0]       nf_s6;
	logic              ok_s6;
	logic [RDEN_W-1:0] as_s6;
	pay_t              pay_s6;

	logic [65:0] bs_ext;
	assign bs_ext = {{2{sq_sb.bs[MUL_W-1]}}, sq_sb.bs};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		nn_s6  <= 66'(0) - bs_ext - {2'b00, sq_root};
		nf_s6  <= 66'(0) - bs_ext + {2'b00, sq_root};
		ok_s6  <= sq_sb.ok;
		as_s6  <= sq_sb.as;
		pay_s6 <= sq_sb.pay;
	end

	// ------------------------------------------- stage 7: numerator magnitudes
	logic              valid_s7;
	logic [64:0]       mn_s7;
	logic [64:0]       mf_s7;
	logic              negf_s7;
	logic [RDEN_W-1:0] as_s7;
	rt_sb_t            rsb_s7;

	logic [65:0] nn_abs;
	logic [65:0] nf_abs;
	assign nn_abs = nn_s6[65] ? (66'(0) - nn_s6) : nn_s6;
	assign nf_abs = nf_s6[65] ? (66'(0) - nf_s6) : nf_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		mn_s7      <= nn_abs[64:0];
		mf_s7      <= nf_abs[64:0];
		negf_s7    <= nf_s6[65];
		as_s7      <= as_s6;
		rsb_s7.neg <= nn_s6[65];
		rsb_s7.ok  <= ok_s6;
		rsb_s7.pay <= pay_s6;
	end

	// --------------------------- roots: (|n| << F) / as, near and far at once
	logic              rn_valid;
	logic [TMAG_W-1:0] qn;
	logic [TMAG_W-1:0] qf;
	logic              ovfn;
	logic              ovff;
	rt_sb_t            rn_sb;
	logic              rf_neg;

	rsi_div #(.NUM_W(RNUM_W), .DEN_W(RDEN_W), .QUO_W(TMAG_W),
		.SB_W($bits(rt_sb_t))) u_div_near (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s7),
		.in_num    (RNUM_W'(mn_s7) << FRAC_BITS),
		.in_den    (as_s7),
		.in_sb     (rsb_s7),
		.out_valid (rn_valid),
		.out_quo   (qn),
		.out_ovf   (ovfn),
		.out_sb    (rn_sb)
	);

	rsi_div #(.NUM_W(RNUM_W), .DEN_W(RDEN_W), .QUO_W(TMAG_W), .SB_W(1)) u_div_far (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s7),
		.in_num    (RNUM_W'(mf_s7) << FRAC_BITS),
		.in_den    (as_s7),
		.in_sb     (negf_s7),
		.out_valid (),
		.out_quo   (qf),
		.out_ovf   (ovff),
		.out_sb    (rf_neg)
	);

	// --------------------------------- stage 8: clamp to +/-2^33 and sign
	logic              valid_s8;
	logic [TMAG_W:0]   tn_s8;
	logic [TMAG_W:0]   tf_s8;
	logic              ok_s8;
	pay_t              pay_s8;

	logic [TMAG_W-1:0] mn_c;
	logic [TMAG_W-1:0] mf_c;
	assign mn_c = (ovfn || (qn > T_CLAMP)) ? T_CLAMP : qn;
	assign mf_c = (ovff || (qf > T_CLAMP)) ? T_CLAMP : qf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s8 <= 1'b0;
		end else begin
			valid_s8 <= rn_valid;
		end
	end

	always_ff @(posedge clk) begin
		tn_s8  <= rn_sb.neg ? ((TMAG_W+1)'(0) - {1'b0, mn_c}) : {1'b0, mn_c};
		tf_s8  <= rf_neg ? ((TMAG_W+1)'(0) - {1'b0, mf_c}) : {1'b0, mf_c};
		ok_s8  <= rn_sb.ok;
		pay_s8 <= rn_sb.pay;
	end

	// ---------------------- stage 9: near root first, then far, in (lo, hi)
	logic               valid_s9;
	logic               hit_s9;
	logic [COORD_W-1:0] t_s9;
	pay_t               pay_s9;

	logic signed [TMAG_W:0] lo_ext;
	logic signed [TMAG_W:0] hi_ext;
	logic                   in_n;
	logic                   in_f;

	always_comb begin
		lo_ext = (TMAG_W+1)'($signed(pay_s8.t_lo));
		hi_ext = (TMAG_W+1)'($signed(pay_s8.t_hi));
		in_n   = ok_s8 && ($signed(tn_s8) > lo_ext) && ($signed(tn_s8) < hi_ext);
		in_f   = ok_s8 && ($signed(tf_s8) > lo_ext) && ($signed(tf_s8) < hi_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s9 <= 1'b0;
		end else begin
			valid_s9 <= valid_s8;
		end
	end

	// a root inside the interval always fits 32 bits
	always_ff @(posedge clk) begin
		hit_s9 <= in_n || in_f;
		t_s9   <= in_n ? tn_s8[COORD_W-1:0] : tf_s8[COORD_W-1:0];
		pay_s9 <= pay_s8;
	end

	// ----------------------------------------------- stage 10: t*d
	logic               valid_s10;
	logic [63:0]        td_s10 [0:2];
	logic               hit_s10;
	logic [COORD_W-1:0] t_s10;
	pay_t               pay_s10;

	logic signed [63:0] td_w [0:2];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			td_w[i] = $signed(t_s9) * $signed(pay_s9.d[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s10 <= 1'b0;
		end else begin
			valid_s10 <= valid_s9;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			td_s10[i] <= td_w[i];
		end
		hit_s10 <= hit_s9;
		t_s10   <= t_s9;
		pay_s10 <= pay_s9;
	end

	// ------------------------- stage 11: v = oc*2^F + t*d, 64-bit wrap
	logic               valid_s11;
	logic [63:0]        v_s11 [0:2];
	logic               hit_s11;
	logic [COORD_W-1:0] t_s11;
	logic [COORD_W-1:0] thi_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s11 <= 1'b0;
		end else begin
			valid_s11 <= valid_s10;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			v_s11[i] <= (64'($signed(pay_s10.oc[i])) << FRAC_BITS) + td_s10[i];
		end
		hit_s11 <= hit_s10;
		t_s11   <= t_s10;
		thi_s11 <= pay_s10.t_hi;
	end

	// ------------------------------------------ stage 12: |v| and sign
	logic               valid_s12;
	logic [63:0]        vm_s12 [0:2];
	logic [2:0]         vneg_s12;
	nm_sb_t             nsb_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s12 <= 1'b0;
		end else begin
			valid_s12 <= valid_s11;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			vm_s12[i]   <= v_s11[i][63] ? (64'(0) - v_s11[i]) : v_s11[i];
			vneg_s12[i] <= v_s11[i][63];
		end
		nsb_s12.neg  <= v_s11[0][63];
		nsb_s12.hit  <= hit_s11;
		nsb_s12.t    <= t_s11;
		nsb_s12.t_hi <= thi_s11;
	end

	// --------------------------- normals: (|v| << 14) / (r << F), 15 bits
	logic [NDEN_W-1:0] nden;
	assign nden = NDEN_W'(radius_q) << FRAC_BITS;

	logic              nx_valid;
	logic [NQUO_W-1:0] nq [0:2];
	logic [2:0]        novf;
	nm_sb_t            nx_sb;
	logic              ny_neg;
	logic              nz_neg;

	rsi_div #(.NUM_W(NNUM_W), .DEN_W(NDEN_W), .QUO_W(NQUO_W),
		.SB_W($bits(nm_sb_t))) u_div_nx (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s12),
		.in_num    (NNUM_W'(vm_s12[0]) << NORM_BITS),
		.in_den    (nden),
		.in_sb     (nsb_s12),
		.out_valid (nx_valid),
		.out_quo   (nq[0]),
		.out_ovf   (novf[0]),
		.out_sb    (nx_sb)
	);

	rsi_div #(.NUM_W(NNUM_W), .DEN_W(NDEN_W), .QUO_W(NQUO_W), .SB_W(1)) u_div_ny (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s12),
		.in_num    (NNUM_W'(vm_s12[1]) << NORM_BITS),
		.in_den    (nden),
		.in_sb     (vneg_s12[1]),
		.out_valid (),
		.out_quo   (nq[1]),
		.out_ovf   (novf[1]),
		.out_sb    (ny_neg)
	);

	rsi_div #(.NUM_W(NNUM_W), .DEN_W(NDEN_W), .QUO_W(NQUO_W), .SB_W(1)) u_div_nz (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s12),
		.in_num    (NNUM_W'(vm_s12[2]) << NORM_BITS),
		.in_den    (nden),
		.in_sb     (vneg_s12[2]),
		.out_valid (),
		.out_quo   (nq[2]),
		.out_ovf   (novf[2]),
		.out_sb    (nz_neg)
	);

	// ------------------------------------ output: saturate, miss masking
	function automatic logic [NORMAL_W-1:0] sat_normal(
		input logic              neg,
		input logic              ovf,
		input logic [NQUO_W-1:0] q
	);
		logic [NORMAL_W-1:0] mag;
		mag = {1'b0, q};
		if (neg) begin
			sat_normal = ovf ? {1'b1, {NQUO_W{1'b0}}} : (NORMAL_W'(0) - mag);
		end else begin
			sat_normal = ovf ? {1'b0, {NQUO_W{1'b1}}} : mag;
		end
	endfunction

	logic [2:0] nneg;
	logic       nvalid_out;
	assign nneg = {nz_neg, ny_neg, nx_sb.neg};
	// zero radius gives a zero normal on a hit
	assign nvalid_out = nx_sb.hit && (radius_q != '0);

	logic                done_q;
	logic                hit_q;
	logic [COORD_W-1:0]  thit_q;
	logic [NORMAL_W-1:0] nrm_q [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= nx_valid;
		end
	end

	always_ff @(posedge clk) begin
		hit_q  <= nx_sb.hit;
		thit_q <= nx_sb.hit ? nx_sb.t : nx_sb.t_hi;
		for (int i = 0; i < 3; i++) begin
			nrm_q[i] <= nvalid_out ? sat_normal(nneg[i], novf[i], nq[i]) : '0;
		end
	end

	assign done     = done_q;
	assign hit      = hit_q;
	assign t_hit    = thit_q;
	assign normal_x = nrm_q[0];
	assign normal_y = nrm_q[1];
	assign normal_z = nrm_q[2];

endmodule

// File: sim/testbench.sv
module testbench;
	import rsi_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_DEPTH = 130;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic signed [COORD_W-1:0] ox, oy, oz;
		logic signed [COORD_W-1:0] dx, dy, dz;
		logic signed [COORD_W-1:0] tmin, tmax;
	} ray_t;

	typedef struct {
		logic                       hit;
		logic signed [COORD_W-1:0]  t_hit;
		logic signed [NORMAL_W-1:0] nx, ny, nz;
	} isect_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [1:0] cfg_index;
	logic [COORD_W-1:0] cfg_data;
	logic start;
	logic busy;
	logic signed [COORD_W-1:0] origin_x, origin_y, origin_z;
	logic signed [COORD_W-1:0] dir_x, dir_y, dir_z;
	logic signed [COORD_W-1:0] t_min, t_max;
	logic done;
	logic hit;
	logic signed [COORD_W-1:0] t_hit;
	logic signed [NORMAL_W-1:0] normal_x, normal_y, normal_z;

	ray_sphere_intersect u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.start    (start),
		.busy     (busy),
		.origin_x (origin_x),
		.origin_y (origin_y),
		.origin_z (origin_z),
		.dir_x    (dir_x),
		.dir_y    (dir_y),
		.dir_z    (dir_z),
		.t_min    (t_min),
		.t_max    (t_max),
		.done     (done),
		.hit      (hit),
		.t_hit    (t_hit),
		.normal_x (normal_x),
		.normal_y (normal_y),
		.normal_z (normal_z)
	);

	// shadow copy of the sphere registers
	logic [RADIUS_W-1:0]       sph_radius;
	logic signed [COORD_W-1:0] sph_cx, sph_cy, sph_cz;

	isect_t pending_isects[$];
	int     mismatch_cnt;
	int     burst_left;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// generous cap on the whole run
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// floor(sqrt(v)), v < 2^127
	function automatic logic [63:0] isqrt128(logic [127:0] v);
		logic [63:0]  r;
		logic [63:0]  cand;
		logic [127:0] cw;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			cand = r | (64'd1 << i);
			cw = {64'd0, cand};
			if (cw * cw <= v)
				r = cand;
		end
		return r;
	endfunction

	// one root of the halved quadratic, truncated toward zero, clamped to +/-2^33
	function automatic logic signed [63:0] quad_root(logic signed [63:0] bs, logic [63:0] s,
			bit far_root, logic [63:0] as);
		logic signed [127:0] n;
		logic [127:0] num;
		logic [127:0] quo;
		logic [63:0]  m;
		bit           neg;
		n = -128'(bs);
		n = far_root ? n + $signed({64'd0, s}) : n - $signed({64'd0, s});
		neg = n < 0;
		num = neg ? -n : n;
		num = num << FRAC_BITS;
		quo = num / {64'd0, as};
		m = (quo > (128'd1 << 33)) ? (64'd1 << 33) : quo[63:0];
		return neg ? -$signed(m) : $signed(m);
	endfunction

	// (oc + t*d) / r as Q1.14, saturated
	function automatic logic signed [NORMAL_W-1:0] unit_normal(logic signed [63:0] oc,
			logic signed [63:0] d, logic signed [63:0] t, logic [RADIUS_W-1:0] r);
		logic signed [63:0] v;
		logic [63:0]  m;
		logic [127:0] x;
		logic [127:0] den;
		logic [127:0] q;
		if (r == 0)
			return '0;
		v = (oc <<< FRAC_BITS) + t * d;   // wraps at 64 bits
		m = (v < 0) ? -v : v;
		x = {64'd0, m} << NORM_BITS;
		den = {97'd0, r} << FRAC_BITS;
		q = x / den;
		if (v < 0)
			return (q >= 128'd32768) ? 16'sh8000 : -$signed(q[15:0]);
		return (q > 128'd32767) ? 16'sh7FFF : $signed(q[15:0]);
	endfunction

	function automatic isect_t trace_sphere(ray_t ray);
		logic signed [63:0]  oc[3];
		logic signed [63:0]  d[3];
		logic signed [127:0] wd, wo, wb, wc, disc, rr;
		logic [63:0]         a_sum, as, s;
		logic signed [63:0]  bs, cs, t;
		logic signed [63:0]  lo, hi_b;
		isect_t res;
		oc[0] = ray.ox - sph_cx;
		oc[1] = ray.oy - sph_cy;
		oc[2] = ray.oz - sph_cz;
		d[0] = ray.dx;
		d[1] = ray.dy;
		d[2] = ray.dz;
		lo = ray.tmin;
		hi_b = ray.tmax;
		a_sum = '0;
		wb = '0;
		wc = '0;
		for (int i = 0; i < 3; i++) begin
			wd = d[i];
			wo = oc[i];
			a_sum = a_sum + 64'(d[i] * d[i]);
			wb = wb + wd * wo;
			wc = wc + wo * wo;
		end
		rr = $signed({97'd0, sph_radius});
		wc = wc - rr * rr;
		as = a_sum >> 2;
		bs = wb[65:2];
		cs = wc[65:2];
		disc = 128'(bs) * 128'(bs) - $signed({64'd0, as}) * 128'(cs);
		res.hit = 1'b0;
		t = '0;
		if (as != 0 && disc > 0) begin
			s = isqrt128(disc);
			t = quad_root(bs, s, 1'b0, as);
			if (t > lo && t < hi_b) begin
				res.hit = 1'b1;
			end else begin
				t = quad_root(bs, s, 1'b1, as);
				res.hit = (t > lo && t < hi_b);
			end
		end
		if (res.hit) begin
			res.t_hit = t[31:0];
			res.nx = unit_normal(oc[0], d[0], t, sph_radius);
			res.ny = unit_normal(oc[1], d[1], t, sph_radius);
			res.nz = unit_normal(oc[2], d[2], t, sph_radius);
		end else begin
			res.t_hit = ray.tmax;
			res.nx = '0;
			res.ny = '0;
			res.nz = '0;
		end
		return res;
	endfunction

	// ---------------------------------------------------------------
	// Result checker: done is a one-cycle strobe, no back-pressure
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		isect_t want;
		if (arst_n && done) begin
			if (pending_isects.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTS)
					$display("[%0t] unexpected result: hit=%0b t=%h", $realtime, hit, t_hit);
			end else begin
				want = pending_isects.pop_front();
				if (hit !== want.hit || t_hit !== want.t_hit || normal_x !== want.nx ||
						normal_y !== want.ny || normal_z !== want.nz) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$display("[%0t] mismatch exp hit=%0b t=%h n=%h/%h/%h got hit=%0b t=%h n=%h/%h/%h",
							$realtime, want.hit, want.t_hit, want.nx, want.ny, want.nz,
							hit, t_hit, normal_x, normal_y, normal_z);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Driver tasks
	// ---------------------------------------------------------------

	// one request; start stays high unless a gap follows
	task automatic send_ray(ray_t ray);
		origin_x <= ray.ox;
		origin_y <= ray.oy;
		origin_z <= ray.oz;
		dir_x <= ray.dx;
		dir_y <= ray.dy;
		dir_z <= ray.dz;
		t_min <= ray.tmin;
		t_max <= ray.tmax;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_isects.push_back(trace_sphere(ray));
		// bursty sender: random burst lengths, random gaps, some long runs
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 8);
		end
	endtask

	// wait out the pipe so config can change safely
	task automatic drain_pipe();
		start <= 1'b0;
		@(posedge clk);
		while (pending_isects.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
	endtask

	// write enable stays high for back-to-back writes; the caller drops it
	task automatic write_reg(logic [1:0] idx, logic [COORD_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_RADIUS:   sph_radius = val[RADIUS_W-1:0];
			REG_CENTER_X: sph_cx = val;
			REG_CENTER_Y: sph_cy = val;
			default:      sph_cz = val;
		endcase
	endtask

	task automatic set_sphere(logic [RADIUS_W-1:0] r, logic [COORD_W-1:0] cx,
			logic [COORD_W-1:0] cy, logic [COORD_W-1:0] cz);
		drain_pipe();
		write_reg(REG_RADIUS, {1'b0, r});
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CENTER_Z, cz);
		cfg_wr_en <= 1'b0;
	endtask

	function automatic ray_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz,
			int tmin, int tmax);
		ray_t r;
		r.ox = ox; r.oy = oy; r.oz = oz;
		r.dx = dx; r.dy = dy; r.dz = dz;
		r.tmin = tmin; r.tmax = tmax;
		return r;
	endfunction

	function automatic ray_t noise_ray();
		return make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom);
	endfunction

	// ray aimed near the sphere, origin offset by a random span from the center
	function automatic ray_t aimed_ray();
		ray_t r;
		int span, jit, sh;
		span = 1 << $urandom_range(12, 22);
		jit = int'(sph_radius >> $urandom_range(0, 3));
		r.ox = sph_cx + $signed($urandom_range(0, 2 * span)) - span;
		r.oy = sph_cy + $signed($urandom_range(0, 2 * span)) - span;
		r.oz = sph_cz + $signed($urandom_range(0, 2 * span)) - span;
		sh = $urandom_range(0, 4);
		r.dx = (sph_cx + $signed($urandom_range(0, 2 * jit)) - jit - r.ox) >>> sh;
		r.dy = (sph_cy + $signed($urandom_range(0, 2 * jit)) - jit - r.oy) >>> sh;
		r.dz = (sph_cz + $signed($urandom_range(0, 2 * jit)) - jit - r.oz) >>> sh;
		case ($urandom_range(0, 3))
			0: r.tmin = 0;
			1: r.tmin = 32'sh80000000;
			2: r.tmin = $urandom_range(0, 1 << 17);
			default: r.tmin = -$signed($urandom_range(0, 1 << 20));
		endcase
		r.tmax = ($urandom_range(0, 1) == 0) ? 32'sh7FFFFFFF :
			r.tmin + $signed($urandom_range(1, 1 << 24));
		return r;
	endfunction

	// mostly aimed rays, some noise
	task automatic random_rays(int n);
		for (int i = 0; i < n; i++)
			send_ray(($urandom_range(0, 9) < 8) ? aimed_ray() : noise_ray());
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// reset sphere: unit radius at the origin
	task automatic test_directed();
		localparam int ONE = 1 << FRAC_BITS;
		localparam int INF = 32'h7FFFFFFF;
		burst_left = 100;
		// straight hit along each axis, both signs
		send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0, 0, INF));
		send_ray(make_ray(0, 5 * ONE, 0, 0, -ONE, 0, 0, INF));
		send_ray(make_ray(0, 0, -5 * ONE, 0, 0, 2 * ONE, 0, INF));
		// grazing ray, discriminant exactly zero: miss
		send_ray(make_ray(-5 * ONE, ONE, 0, ONE, 0, 0, 0, INF));
		// origin inside: nearer root behind, farther root taken
		send_ray(make_ray(0, 0, 0, ONE, 0, 0, 0, INF));
		// both roots outside the interval
		send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0, 0, 2 * ONE));
		send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0, 7 * ONE, INF));
		// zero direction
		send_ray(make_ray(-5 * ONE, 0, 0, 0, 0, 0, 0, INF));
		// tiny direction rounds A to zero
		send_ray(make_ray(-5 * ONE, 0, 0, 1, 0, 0, 0, INF));
		// empty interval, equal and inverted
		send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0, 3 * ONE, 3 * ONE));
		send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0, INF, 32'sh80000000));
		// ray pointing away
		send_ray(make_ray(-5 * ONE, 0, 0, -ONE, 0, 0, 0, INF));
		// negative interval catches roots behind the origin
		send_ray(make_ray(5 * ONE, 0, 0, ONE, 0, 0, 32'sh80000000, 0));
		// field extremes
		send_ray(make_ray(32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, INF));
		send_ray(make_ray(INF, INF, INF, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh80000000, INF));
		send_ray(make_ray(INF, 0, 0, 32'sh80000000, 0, 0, 0, INF));
		send_ray(make_ray(-1, -1, -1, -1, -1, -1, -1, -1));
		send_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0));
		// huge t beyond the clamp
		send_ray(make_ray(32'sh80000000, 0, 0, 1 << 2, 0, 0, 0, INF));
		// diagonal hit, normal on all three axes
		send_ray(make_ray(-3 * ONE, -3 * ONE, -3 * ONE, ONE, ONE, ONE, 0, INF));
	endtask

	task automatic test_moderate_sphere();
		set_sphere($urandom_range(1 << 15, 1 << 19), $signed($urandom_range(0, 1 << 21)) - (1 << 20),
			$signed($urandom_range(0, 1 << 21)) - (1 << 20),
			$signed($urandom_range(0, 1 << 21)) - (1 << 20));
		random_rays(400);
	endtask

	task automatic test_smallest_radius();
		set_sphere(31'd1, $urandom, $urandom, $urandom);
		random_rays(300);
	endtask

	task automatic test_largest_radius();
		set_sphere(31'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
		random_rays(300);
	endtask

	task automatic test_extreme_centers();
		set_sphere($urandom_range(1 << 10, 1 << 24), 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		random_rays(300);
	endtask

	task automatic test_random_spheres();
		for (int k = 0; k < 4; k++) begin
			set_sphere($urandom_range(1, 32'h7FFFFFFF) >> $urandom_range(0, 20),
				$urandom >> $urandom_range(0, 12), $urandom, $urandom >> $urandom_range(0, 12));
			random_rays(130);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_RADIUS;
		cfg_data <= '0;
		start <= 1'b0;
		origin_x <= '0;
		origin_y <= '0;
		origin_z <= '0;
		dir_x <= '0;
		dir_y <= '0;
		dir_z <= '0;
		t_min <= '0;
		t_max <= '0;
		sph_radius = RADIUS_RESET;
		sph_cx = '0;
		sph_cy = '0;
		sph_cz = '0;
		mismatch_cnt = 0;
		burst_left = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_moderate_sphere();
		test_smallest_radius();
		test_largest_radius();
		test_extreme_centers();
		test_random_spheres();
		drain_pipe();

		if (mismatch_cnt == 0 && pending_isects.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
